// ===== rtl/core/multi_stream_byte_ring_buffer_defines.svh =====
// Assertion macros used by the ring buffer back end.
`ifndef MULTI_STREAM_BYTE_RING_BUFFER_DEFINES_SVH
`define MULTI_STREAM_BYTE_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define MBRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define MBRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mbrb_pkg.sv =====
// Shared sizes, codes and the request type of the multi-stream byte ring buffer.
package mbrb_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int MAX_STREAMS  = 8;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int HW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = $clog2(MAX_STREAMS);
  localparam int CW = $clog2(MAX_STREAMS + 1);

  // Command codes on in_cmd.
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_OPEN  = 3'd2;
  localparam logic [2:0] CMD_CLOSE = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;

  // Status codes on out_status.
  localparam logic [2:0] STS_DONE       = 3'd0;
  localparam logic [2:0] STS_DROPPED    = 3'd1;
  localparam logic [2:0] STS_FULL       = 3'd2;
  localparam logic [2:0] STS_TABLE_FULL = 3'd3;
  localparam logic [2:0] STS_WAIT       = 3'd4;

  // Stream marks on out_stream_mark.
  localparam logic [1:0] MARK_CONT  = 2'd0;
  localparam logic [1:0] MARK_START = 2'd1;
  localparam logic [1:0] MARK_END   = 2'd2;

  // One classified request. Unused command codes have no flag set.
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       opn;
    logic       cls;
    logic       fls;
    logic [7:0] data;
  } item_t;

  // Head of the request queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ===== rtl/core/multi_stream_byte_ring_buffer.sv =====
// Top level of the multi-stream byte ring buffer.
// A request is taken when start is high and busy is low; busy only rises when
// the two-entry request queue is full. Every request yields exactly one result,
// shown for a single cycle with out_strobe high, and the receiver cannot stall
// it. Write, open, close, flush and a read that finds no byte or no stream are
// answered from the idle state, and the back end retires one such request per
// cycle. A read that finds bytes sends the back end to its skip state, which
// drops each drained stream from the front of the stream queue and then reads
// the byte store; the result and the byte are registered together, and no new
// request is taken from the queue meanwhile. cfg_we writes the nonblocking read
// flag and should only be used while no request is pending.
module multi_stream_byte_ring_buffer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_cmd,
  input  logic [7:0]              in_data_in,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  output logic                    out_strobe,
  output logic [2:0]              out_status,
  output logic [7:0]              out_data_byte,
  output logic                    out_data_valid,
  output logic [1:0]              out_stream_mark,
  output logic [mbrb_pkg::HW-1:0] out_bytes_held
);
  import mbrb_pkg::*;

  // Queue head handed from the decoder to the execution side.
  head_t head;
  logic  pop;

  // Front end: decodes each request and buffers up to two of them so the
  // sender keeps going while a read is searching for data.
  mbrb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .in_data_in (in_data_in),
    .pop        (pop),
    .head       (head)
  );

  // Back end: owns the byte store, the stream table and the result register.
  mbrb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_data_byte   (out_data_byte),
    .out_data_valid  (out_data_valid),
    .out_stream_mark (out_stream_mark),
    .out_bytes_held  (out_bytes_held)
  );

endmodule

// ===== rtl/core/mbrb_front.sv =====
// Front end: takes requests, decodes the command and queues them for the back end.
module mbrb_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     in_cmd,
  input  logic [7:0]     in_data_in,
  input  logic           pop,
  output mbrb_pkg::head_t head
);
  import mbrb_pkg::*;

  item_t      q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  item_t      dec;
  logic       push;
  logic       pop_ok;

  always_comb begin
    dec      = '0;
    dec.data = in_data_in;
    case (in_cmd)
      CMD_WRITE: dec.wr  = 1'b1;
      CMD_READ:  dec.rd  = 1'b1;
      CMD_OPEN:  dec.opn = 1'b1;
      CMD_CLOSE: dec.cls = 1'b1;
      CMD_FLUSH: dec.fls = 1'b1;
      default:   dec.data = in_data_in;
    endcase
  end

  assign busy   = (count_r == 2'd2);
  assign push   = start && !busy;
  assign pop_ok = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop_ok ? ~rptr_r : rptr_r;
    count_nxt = count_r;
    if (push && !pop_ok) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop_ok) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= dec;
    end
  end

endmodule

// ===== rtl/core/mbrb_back.sv =====
// Back end: executes queued requests against the byte store and the stream table.
`include "multi_stream_byte_ring_buffer_defines.svh"
module mbrb_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mbrb_pkg::head_t         head,
  output logic                    pop,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  output logic                    out_strobe,
  output logic [2:0]              out_status,
  output logic [7:0]              out_data_byte,
  output logic                    out_data_valid,
  output logic [1:0]              out_stream_mark,
  output logic [mbrb_pkg::HW-1:0] out_bytes_held
);
  import mbrb_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SKIP = 1'b1;

  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] base,
                                             input logic [SW-1:0] off);
    logic [SW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (SW+1)'(MAX_STREAMS)) begin
      sum = sum - (SW+1)'(MAX_STREAMS);
    end
    return sum[SW-1:0];
  endfunction

  logic [7:0]       mem [BUFFER_BYTES];
  logic [7:0]       rdata_r;

  logic             state_r, state_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [HW-1:0]    total_r, total_nxt;
  logic [HW-1:0]    left_r [MAX_STREAMS];
  logic [HW-1:0]    left_nxt [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] started_r, started_nxt;
  logic [MAX_STREAMS-1:0] ended_r, ended_nxt;
  logic [SW-1:0]    oldest_r, oldest_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             closed_r, closed_nxt;
  logic             rwait_r, rwait_nxt;
  logic             nb_r;

  logic             strobe_r, strobe_nxt;
  logic [2:0]       status_r, status_nxt;
  logic             valid_r, valid_nxt;
  logic [1:0]       mark_r, mark_nxt;
  logic [HW-1:0]    held_r;

  logic [MAX_STREAMS-1:0] drained;
  logic [MAX_STREAMS-1:0] one_left;
  logic [SW-1:0]    newest;
  logic [SW-1:0]    oldest_inc;
  logic [SW-1:0]    new_slot;
  logic             table_full;
  logic             mem_we, mem_re;
  logic             inc_en, dec_en, clr_en, start_en, end_en, clear_all;

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      drained[i]  = (left_r[i] == '0);
      one_left[i] = (left_r[i] == HW'(1));
    end
  end

  assign newest     = slot_add(oldest_r, SW'(cnt_r - CW'(1)));
  assign oldest_inc = slot_add(oldest_r, SW'(1));
  assign table_full = (cnt_r == CW'(MAX_STREAMS));
  assign pop        = (state_r == S_IDLE) && head.valid;

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    total_nxt  = total_r;
    oldest_nxt = oldest_r;
    cnt_nxt    = cnt_r;
    closed_nxt = closed_r;
    rwait_nxt  = rwait_r;
    strobe_nxt = 1'b0;
    status_nxt = STS_DONE;
    valid_nxt  = 1'b0;
    mark_nxt   = MARK_CONT;
    new_slot   = slot_add(oldest_r, SW'(cnt_r));
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    inc_en     = 1'b0;
    dec_en     = 1'b0;
    clr_en     = 1'b0;
    start_en   = 1'b0;
    end_en     = 1'b0;
    clear_all  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          strobe_nxt = 1'b1;
          if (head.item.wr) begin
            if (cnt_r == '0 || ended_r[newest]) begin
              status_nxt = STS_DROPPED;
            end else if (total_r >= HW'(BUFFER_BYTES)) begin
              status_nxt = STS_FULL;
            end else begin
              mem_we    = 1'b1;
              wp_nxt    = (wp_r == AW'(BUFFER_BYTES - 1)) ? '0 : wp_r + AW'(1);
              total_nxt = total_r + HW'(1);
              inc_en    = 1'b1;
              rwait_nxt = 1'b0;
            end
          end else if (head.item.rd) begin
            if (total_r == '0 || cnt_r == '0) begin
              if (cnt_r == '0) begin
                mark_nxt = MARK_END;
              end else if (nb_r) begin
                mark_nxt = MARK_CONT;
              end else if (closed_r) begin
                closed_nxt = 1'b0;
                mark_nxt   = MARK_END;
              end else begin
                rwait_nxt  = 1'b1;
                status_nxt = STS_WAIT;
              end
            end else begin
              strobe_nxt = 1'b0;
              state_nxt  = S_SKIP;
            end
          end else if (head.item.opn) begin
            if (table_full && drained[oldest_r]) begin
              new_slot   = oldest_r;
              oldest_nxt = oldest_inc;
              clr_en     = 1'b1;
            end else if (table_full) begin
              status_nxt = STS_TABLE_FULL;
            end else begin
              clr_en  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end else if (head.item.cls) begin
            if (cnt_r != '0) begin
              end_en = 1'b1;
              if (rwait_r) begin
                rwait_nxt  = 1'b0;
                closed_nxt = 1'b1;
              end
            end
          end else if (head.item.fls) begin
            clear_all  = 1'b1;
            wp_nxt     = '0;
            rp_nxt     = '0;
            total_nxt  = '0;
            oldest_nxt = '0;
            cnt_nxt    = '0;
            rwait_nxt  = 1'b0;
          end
        end
      end
      S_SKIP: begin
        if (cnt_r > CW'(1) && drained[oldest_r]) begin
          oldest_nxt = oldest_inc;
          cnt_nxt    = cnt_r - CW'(1);
        end else if (drained[oldest_r]) begin
          strobe_nxt = 1'b1;
          mark_nxt   = MARK_END;
          state_nxt  = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          rp_nxt     = (rp_r == AW'(BUFFER_BYTES - 1)) ? '0 : rp_r + AW'(1);
          total_nxt  = total_r - HW'(1);
          dec_en     = 1'b1;
          start_en   = 1'b1;
          strobe_nxt = 1'b1;
          valid_nxt  = 1'b1;
          if (one_left[oldest_r] && ended_r[oldest_r]) begin
            mark_nxt = MARK_END;
          end else if (started_r[oldest_r]) begin
            mark_nxt = MARK_CONT;
          end else begin
            mark_nxt = MARK_START;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Per-stream counters and flags; a flush clears every slot, otherwise at most one slot changes per cycle.
  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      left_nxt[i]    = left_r[i];
      started_nxt[i] = started_r[i];
      ended_nxt[i]   = ended_r[i];
      if (clear_all || (clr_en && new_slot == SW'(i))) begin
        left_nxt[i]    = '0;
        started_nxt[i] = 1'b0;
        ended_nxt[i]   = 1'b0;
      end else begin
        if (inc_en && newest == SW'(i)) begin
          left_nxt[i] = left_r[i] + HW'(1);
        end
        if (dec_en && oldest_r == SW'(i)) begin
          left_nxt[i] = left_r[i] - HW'(1);
        end
        if (start_en && oldest_r == SW'(i)) begin
          started_nxt[i] = 1'b1;
        end
        if (end_en && newest == SW'(i)) begin
          ended_nxt[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      rp_r      <= '0;
      total_r   <= '0;
      started_r <= '0;
      ended_r   <= '0;
      oldest_r  <= '0;
      cnt_r     <= '0;
      closed_r  <= 1'b0;
      rwait_r   <= 1'b0;
      nb_r      <= 1'b0;
      strobe_r  <= 1'b0;
      for (int i = 0; i < MAX_STREAMS; i++) begin
        left_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      total_r   <= total_nxt;
      started_r <= started_nxt;
      ended_r   <= ended_nxt;
      oldest_r  <= oldest_nxt;
      cnt_r     <= cnt_nxt;
      closed_r  <= closed_nxt;
      rwait_r   <= rwait_nxt;
      strobe_r  <= strobe_nxt;
      if (cfg_we) begin
        nb_r <= cfg_wdata;
      end
      for (int i = 0; i < MAX_STREAMS; i++) begin
        left_r[i] <= left_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    valid_r  <= valid_nxt;
    mark_r   <= mark_nxt;
    held_r   <= total_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= head.item.data;
    end
    if (mem_re) begin
      rdata_r <= mem[rp_r];
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_data_valid  = valid_r;
  assign out_data_byte   = valid_r ? rdata_r : 8'd0;
  assign out_stream_mark = mark_r;
  assign out_bytes_held  = held_r;

  `MBRB_ASSERT_IMP(a_held_bound, 1'b1, total_r <= HW'(BUFFER_BYTES), "byte count overflow")
  `MBRB_ASSERT_IMP(a_no_stream_no_bytes, cnt_r == '0, total_r == '0, "bytes held without stream")
  `MBRB_ASSERT_IMP(a_skip_has_data, state_r == S_SKIP, cnt_r != '0 && total_r != '0,
                   "stream search entered with empty buffer")
  `MBRB_ASSERT_NXT(a_write_answers, state_r == S_IDLE && head.valid && head.item.wr,
                   strobe_r, "write request produced no result")

endmodule
